>>> hw/rtl/hop_table_packet_router_macros.svh
// ----------------------------------------------------------------------------
// Hop table packet router assertion macros
// Shared helpers for the concurrent checks of the router, clocked on clk and
// held off while rst is high.
// ----------------------------------------------------------------------------
`ifndef HOP_TABLE_PACKET_ROUTER_MACROS_SVH
`define HOP_TABLE_PACKET_ROUTER_MACROS_SVH

// Same-cycle implication.
`define HTPR_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define HTPR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> hw/rtl/htpr_pkg.sv
// ----------------------------------------------------------------------------
// Hop table packet router package
// Sizes, codes and shared control types of the router.
// ----------------------------------------------------------------------------
`default_nettype none

package htpr_pkg;

  localparam int NODES     = 256;
  localparam int PORTS     = 4;
  localparam int FAN       = (PORTS < 4) ? PORTS : 4;
  localparam int NODE_W    = $clog2(NODES);
  localparam int ENTRY_W   = 8;
  localparam int ROW_W     = PORTS * ENTRY_W;
  localparam int OCC_Q_W   = 7;
  localparam int COST_W    = ENTRY_W + 1;
  localparam int DIV3_MUL  = 171;
  localparam int DIV3_SHIFT = 9;

  localparam int IN_W      = 80;
  localparam int OUT_W     = 48;
  localparam int USER_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 8;

  localparam logic [7:0] ACK_LEN = 8'd5;

  typedef enum logic [1:0] {
    ACT_LOCAL_PKT = 2'd0,
    ACT_LOCAL_ACK = 2'd1,
    ACT_SEND      = 2'd2,
    ACT_UNKNOWN   = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MY_ADDRESS          = 3'd0,
    REG_HOP_LIMIT           = 3'd1,
    REG_CODE_STANDARD       = 3'd2,
    REG_CODE_ACK            = 3'd3,
    REG_CODE_STANDARD_FLOOD = 3'd4,
    REG_CODE_ACK_FLOOD      = 3'd5
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN,
    KIND_LOCAL_PKT,
    KIND_LOCAL_ACK,
    KIND_FORWARD
  } kind_t;

  typedef enum logic [1:0] {
    SEL_LOCAL,
    SEL_ROUTE,
    SEL_FLOOD
  } out_sel_t;

  typedef struct packed {
    logic [7:0] my_address;
    logic [7:0] hop_limit;
    logic [7:0] code_standard;
    logic [7:0] code_ack;
    logic [7:0] code_standard_flood;
    logic [7:0] code_ack_flood;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     update;
    logic     evaluate;
    logic     load;
    out_sel_t sel;
    logic     last;
  } cmd_t;

  typedef struct packed {
    logic  drop;
    kind_t kind;
    logic  has_route;
    logic  flood_last;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/htpr_regs.sv
// ----------------------------------------------------------------------------
// Hop table packet router configuration registers
// Holds the node address, hop limit and the four packet type codes.
// ----------------------------------------------------------------------------
`default_nettype none

module htpr_regs import htpr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.my_address          <= 8'd0;
      cfg.hop_limit           <= 8'd254;
      cfg.code_standard       <= 8'd0;
      cfg.code_ack            <= 8'd1;
      cfg.code_standard_flood <= 8'd2;
      cfg.code_ack_flood      <= 8'd3;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MY_ADDRESS:          cfg.my_address          <= cfg_data;
        REG_HOP_LIMIT:           cfg.hop_limit           <= cfg_data;
        REG_CODE_STANDARD:       cfg.code_standard       <= cfg_data;
        REG_CODE_ACK:            cfg.code_ack            <= cfg_data;
        REG_CODE_STANDARD_FLOOD: cfg.code_standard_flood <= cfg_data;
        REG_CODE_ACK_FLOOD:      cfg.code_ack_flood      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/htpr_dp.sv
// ----------------------------------------------------------------------------
// Hop table packet router datapath
// Header capture, hop table memory with row valid flags, route cost
// evaluation and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module htpr_dp import htpr_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IN_W-1:0]   s_tdata,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output status_t                status,
  output logic [OUT_W-1:0]       m_tdata,
  output logic [USER_W-1:0]      m_tuser,
  output logic                   m_tlast
);

  logic [1:0]         arr_q;
  logic [7:0]         type_q;
  logic [7:0]         dest_q;
  logic [7:0]         hop_q;
  logic [7:0]         src_q;
  logic [7:0]         len_q;
  logic [OCC_Q_W-1:0] occ3_q [4];

  logic [ROW_W-1:0]   hop_mem [NODES];
  logic [NODES-1:0]   row_vld;
  logic [ROW_W-1:0]   mem_q;
  logic               vld_q;
  logic [NODE_W-1:0]  rd_idx;
  logic [NODE_W-1:0]  src_idx;
  logic [NODE_W-1:0]  route_idx;
  logic [7:0]         route_node;
  logic               route_ok;
  logic               src_ok;
  logic [ROW_W-1:0]   cur_row;
  logic [ROW_W-1:0]   upd_row;
  logic [ROW_W-1:0]   upd_row_q;
  logic               fwd_q;
  logic [ROW_W-1:0]   ev_row;

  logic               has_route_q;
  logic [1:0]         best_q;
  logic [FAN-1:0]     flood_mask;
  logic               ev_route;
  logic [1:0]         ev_best;
  logic [COST_W-1:0]  ev_cost;
  logic [COST_W-1:0]  cost_i;
  logic [FAN-1:0]     mask_init;
  logic [1:0]         flood_port;

  logic               mine;
  logic               is_std;
  logic               is_ack;
  logic               is_sfl;
  logic               is_afl;
  logic [7:0]         hop_inc;
  logic [7:0]         flood_type;
  logic [1:0]         o_port;
  logic [7:0]         o_type;
  logic [7:0]         o_dest;
  logic [7:0]         o_hop;
  logic [7:0]         o_src;
  logic [7:0]         o_len;
  action_t            o_act;

  // Header decode.
  always_comb begin
    mine   = (dest_q == cfg.my_address);
    is_std = (type_q == cfg.code_standard);
    is_ack = !is_std && (type_q == cfg.code_ack);
    is_sfl = !is_std && !is_ack && (type_q == cfg.code_standard_flood);
    is_afl = !is_std && !is_ack && !is_sfl && (type_q == cfg.code_ack_flood);
    status.drop = (hop_q > cfg.hop_limit) && !mine;
    if (!(is_std || is_ack || is_sfl || is_afl)) begin
      status.kind = KIND_UNKNOWN;
    end else if (mine && (is_std || is_sfl)) begin
      status.kind = KIND_LOCAL_PKT;
    end else if (mine) begin
      status.kind = KIND_LOCAL_ACK;
    end else begin
      status.kind = KIND_FORWARD;
    end
    status.has_route  = has_route_q;
    status.flood_last = ((flood_mask & (flood_mask - FAN'(1))) == '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      arr_q  <= s_tdata[1:0];
      type_q <= s_tdata[9:2];
      dest_q <= s_tdata[17:10];
      hop_q  <= s_tdata[25:18];
      src_q  <= s_tdata[33:26];
      len_q  <= s_tdata[41:34];
      for (int i = 0; i < 4; i++) begin
        occ3_q[i] <= OCC_Q_W'((16'(s_tdata[42 + 8*i +: 8]) * 16'(DIV3_MUL)) >> DIV3_SHIFT);
      end
    end
  end

  // Hop table: one row per node, one entry per port.
  always_comb begin
    route_node = (status.kind == KIND_LOCAL_PKT) ? src_q : dest_q;
    route_idx  = route_node[NODE_W-1:0];
    route_ok   = ({1'b0, route_node} < 9'(NODES));
    src_idx    = src_q[NODE_W-1:0];
    src_ok     = ({1'b0, src_q} < 9'(NODES)) && ({2'b00, arr_q} < 4'(PORTS));
    rd_idx     = cmd.capture ? s_tdata[26 +: NODE_W] : route_idx;
    cur_row    = vld_q ? mem_q : '1;
    for (int i = 0; i < PORTS; i++) begin
      if (src_ok && (int'(arr_q) == i) && (hop_q < cur_row[i*ENTRY_W +: ENTRY_W])) begin
        upd_row[i*ENTRY_W +: ENTRY_W] = hop_q;
      end else begin
        upd_row[i*ENTRY_W +: ENTRY_W] = cur_row[i*ENTRY_W +: ENTRY_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= hop_mem[rd_idx];
    if (cmd.update) begin
      hop_mem[src_idx] <= upd_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      vld_q   <= 1'b0;
    end else begin
      vld_q <= row_vld[rd_idx];
      if (cmd.update) begin
        row_vld[src_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      upd_row_q <= upd_row;
      fwd_q     <= (route_idx == src_idx);
    end
  end

  // Route evaluation over the first FAN entries of the route node's row.
  always_comb begin
    ev_row   = fwd_q ? upd_row_q : cur_row;
    ev_route = 1'b0;
    ev_best  = 2'd0;
    ev_cost  = '1;
    cost_i   = '0;
    for (int i = 0; i < FAN; i++) begin
      if (ev_row[i*ENTRY_W +: ENTRY_W] < cfg.hop_limit) begin
        ev_route = route_ok;
      end
      cost_i = {1'b0, ev_row[i*ENTRY_W +: ENTRY_W]} + {2'b00, occ3_q[i]};
      if ((i == 0) || (cost_i < ev_cost)) begin
        ev_cost = cost_i;
        ev_best = 2'(i);
      end
    end
    for (int i = 0; i < FAN; i++) begin
      mask_init[i] = !((status.kind == KIND_FORWARD) && (int'(arr_q) == i));
    end
    flood_port = 2'd0;
    for (int i = FAN - 1; i >= 0; i--) begin
      if (flood_mask[i]) begin
        flood_port = 2'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.evaluate) begin
      has_route_q <= ev_route;
      best_q      <= ev_best;
      flood_mask  <= mask_init;
    end else if (cmd.load && (cmd.sel == SEL_FLOOD)) begin
      flood_mask[flood_port[$clog2(FAN)-1:0]] <= 1'b0;
    end
  end

  // Result word.
  always_comb begin
    hop_inc    = hop_q + 8'd1;
    flood_type = type_q;
    if (is_std) begin
      flood_type = cfg.code_standard_flood;
    end else if (is_ack) begin
      flood_type = cfg.code_ack_flood;
    end
    o_act  = ACT_SEND;
    o_port = (cmd.sel == SEL_FLOOD) ? flood_port : best_q;
    o_type = (cmd.sel == SEL_FLOOD) ? flood_type : type_q;
    o_dest = dest_q;
    o_hop  = hop_inc;
    o_src  = src_q;
    o_len  = len_q;
    if (cmd.sel == SEL_LOCAL) begin
      o_port = 2'd0;
      o_type = type_q;
      unique case (status.kind)
        KIND_UNKNOWN:   o_act = ACT_UNKNOWN;
        KIND_LOCAL_PKT: o_act = ACT_LOCAL_PKT;
        KIND_LOCAL_ACK: o_act = ACT_LOCAL_ACK;
        default:        o_act = ACT_SEND;
      endcase
    end else if (status.kind == KIND_LOCAL_PKT) begin
      o_type = (cmd.sel == SEL_FLOOD) ? cfg.code_ack_flood : cfg.code_ack;
      o_dest = src_q;
      o_hop  = 8'd0;
      o_src  = dest_q;
      o_len  = ACK_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_tdata <= {6'd0, o_len, o_src, o_hop, o_dest, o_type, o_port};
      m_tuser <= o_act;
      m_tlast <= cmd.last;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/htpr_ctrl.sv
// ----------------------------------------------------------------------------
// Hop table packet router controller
// Sequences capture, table update, route evaluation and result emission,
// and owns the input ready and output valid handshake signals.
// ----------------------------------------------------------------------------
`default_nettype none

module htpr_ctrl import htpr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  output logic      m_tvalid,
  input  wire logic m_tready,
  input  status_t   status,
  output cmd_t      cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_EVAL,
    ST_EMIT_LOCAL,
    ST_EMIT_ROUTE
  } state_t;

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.sel    = SEL_LOCAL;
    state_next = state;
    out_free   = !m_tvalid || m_tready;
    unique case (state)
      ST_IDLE: begin
        cmd.capture = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (status.drop) begin
          state_next = ST_IDLE;
        end else begin
          cmd.update = 1'b1;
          state_next = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.evaluate = 1'b1;
        state_next = (status.kind == KIND_FORWARD) ? ST_EMIT_ROUTE : ST_EMIT_LOCAL;
      end
      ST_EMIT_LOCAL: begin
        if (out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = SEL_LOCAL;
          cmd.last = (status.kind != KIND_LOCAL_PKT);
          state_next = (status.kind == KIND_LOCAL_PKT) ? ST_EMIT_ROUTE : ST_IDLE;
        end
      end
      ST_EMIT_ROUTE: begin
        if (out_free) begin
          cmd.load = 1'b1;
          cmd.sel  = status.has_route ? SEL_ROUTE : SEL_FLOOD;
          cmd.last = status.has_route || status.flood_last;
          if (cmd.last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    m_tvalid_next = cmd.load || (m_tvalid && !m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hop_table_packet_router.sv
// ----------------------------------------------------------------------------
// Hop table packet router
// Routes headers by learned hop count per source and port plus a third of occupancy.
// ----------------------------------------------------------------------------
// One header is handled at a time. A dropped header ends in the update state;
// any other runs the hop table read-modify-write and the route lookup on its
// single read port, then emits 1 to 5 result words, one per cycle unless the
// output stalls; the next header is accepted while the last word waits in the
// output register. The table holds 256 rows of four 8-bit entries with a valid
// flag per row, so it reads as all 255 right after reset with no clearing pass.
`default_nettype none

`include "hop_table_packet_router_macros.svh"

module hop_table_packet_router import htpr_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // arrival_port, pkt_type, dest, hopcount, src, length, occupancy_0..3, pad
  input  wire logic [IN_W-1:0]      s_tdata,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // out_port, out_type, out_dest, out_hopcount, out_src, out_length, pad
  output logic [OUT_W-1:0]          m_tdata,
  // action
  output logic [USER_W-1:0]         m_tuser,
  output logic                      m_tlast,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  htpr_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  htpr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  htpr_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cfg     (cfg),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  `HTPR_ASSERT_NEXT(a_one_header, s_tvalid && s_tready, !s_tready, "header accepted twice in a row")
  `HTPR_ASSERT_IMPL(a_load_free, cmd.load, !m_tvalid || m_tready, "output word overwritten")
  `HTPR_ASSERT_IMPL(a_flood_no_route, cmd.load && (cmd.sel == SEL_FLOOD), !status.has_route, "flooded with a known route")
  `HTPR_ASSERT_IMPL(a_no_drop_write, cmd.update, !status.drop, "table written for a dropped header")

endmodule

`default_nettype wire

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// Hop table packet router testbench
// Streams packet headers into the router and checks every result word
// against a cycle-free model of the router. The model learns the hop table
// and predicts local delivery, acks, routing and flooding. Registers are
// reprogrammed between phases, and random idling on both sides varies by phase.
// ----------------------------------------------------------------------------
module tb_top import htpr_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT = 300000;
  localparam int NO_SKIP = 4;
  localparam int MAX_REPORTS = 40;
  localparam int PHASE_HEADERS = 96;

  typedef struct packed {
    logic [3:0][7:0] occ;
    logic [7:0]      len;
    logic [7:0]      src;
    logic [7:0]      hops;
    logic [7:0]      dest;
    logic [7:0]      ptype;
    logic [1:0]      port;
  } pkt_hdr_t;

  typedef struct packed {
    action_t    action;
    logic [1:0] port;
    logic [7:0] ptype;
    logic [7:0] dest;
    logic [7:0] hops;
    logic [7:0] src;
    logic [7:0] len;
    logic       last;
  } route_word_t;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [IN_W-1:0]      s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [OUT_W-1:0]     m_tdata;
  logic [USER_W-1:0]    m_tuser;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  reg_idx_t             cfg_index = REG_MY_ADDRESS;
  logic [CFG_W-1:0]     cfg_data = '0;

  logic [7:0] hop_tbl [NODES*PORTS];
  logic [7:0] my_addr_cfg = 8'd0;
  logic [7:0] max_hops_cfg = 8'd254;
  logic [7:0] std_code = 8'd0;
  logic [7:0] ack_code = 8'd1;
  logic [7:0] std_flood_code = 8'd2;
  logic [7:0] ack_flood_code = 8'd3;

  pkt_hdr_t    headers_pending [$];
  pkt_hdr_t    hdr_live;
  route_word_t fresh_words [$];
  route_word_t route_words_due [$];
  route_word_t seen_word;
  route_word_t due_word;

  int headers_issued = 0;
  int headers_accepted = 0;
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  hop_table_packet_router i_dut (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata, .m_tvalid, .m_tready,
    .m_tdata, .m_tuser, .m_tlast, .cfg_we, .cfg_index, .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_word(action_t act, logic [1:0] port, logic [7:0] t,
                                   logic [7:0] d, logic [7:0] h, logic [7:0] s,
                                   logic [7:0] l);
    route_word_t w;
    w.action = act;
    w.port = port;
    w.ptype = t;
    w.dest = d;
    w.hops = h;
    w.src = s;
    w.len = l;
    w.last = 1'b0;
    fresh_words.push_back(w);
  endfunction

  function automatic bit route_known(logic [7:0] node);
    if (int'(node) >= NODES) return 1'b0;
    for (int i = 0; i < FAN; i++)
      if (hop_tbl[int'(node)*PORTS + i] < max_hops_cfg) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [1:0] cheapest_port(logic [7:0] node,
                                               logic [3:0][7:0] occ);
    int cost;
    int c;
    logic [1:0] best;
    best = 2'd0;
    cost = int'(hop_tbl[int'(node)*PORTS]) + int'(occ[0]) / 3;
    for (int i = 1; i < FAN; i++) begin
      c = int'(hop_tbl[int'(node)*PORTS + i]) + int'(occ[i]) / 3;
      if (c < cost) begin
        cost = c;
        best = 2'(i);
      end
    end
    return best;
  endfunction

  function automatic void send_or_flood(pkt_hdr_t h, int skip, logic [7:0] t,
                                        logic [7:0] ft, logic [7:0] d,
                                        logic [7:0] hp, logic [7:0] s,
                                        logic [7:0] l);
    if (route_known(d)) begin
      add_word(ACT_SEND, cheapest_port(d, h.occ), t, d, hp, s, l);
    end else begin
      for (int i = 0; i < FAN; i++)
        if (i != skip) add_word(ACT_SEND, 2'(i), ft, d, hp, s, l);
    end
  endfunction

  function automatic void predict_routing(pkt_hdr_t h);
    logic [7:0] hops_next;
    logic [7:0] ft;
    bit mine;
    bit is_std;
    bit is_ack;
    bit is_sfl;
    int slot;
    mine = (h.dest == my_addr_cfg);
    if (h.hops > max_hops_cfg && !mine) return;
    fresh_words.delete();
    if (int'(h.src) < NODES && int'(h.port) < PORTS) begin
      slot = int'(h.src)*PORTS + int'(h.port);
      if (hop_tbl[slot] > h.hops) hop_tbl[slot] = h.hops;
    end
    hops_next = h.hops + 8'd1;
    if (h.ptype == std_code || h.ptype == ack_code ||
        h.ptype == std_flood_code || h.ptype == ack_flood_code) begin
      is_std = (h.ptype == std_code);
      is_ack = !is_std && (h.ptype == ack_code);
      is_sfl = !is_std && !is_ack && (h.ptype == std_flood_code);
      if (mine) begin
        if (is_std || is_sfl) begin
          add_word(ACT_LOCAL_PKT, 2'd0, h.ptype, h.dest, hops_next, h.src, h.len);
          send_or_flood(h, NO_SKIP, ack_code, ack_flood_code, h.src, 8'd0, h.dest,
                        ACK_LEN);
        end else begin
          add_word(ACT_LOCAL_ACK, 2'd0, h.ptype, h.dest, hops_next, h.src, h.len);
        end
      end else begin
        ft = h.ptype;
        if (is_std) ft = std_flood_code;
        else if (is_ack) ft = ack_flood_code;
        send_or_flood(h, int'(h.port), h.ptype, ft, h.dest, hops_next, h.src, h.len);
      end
    end else begin
      add_word(ACT_UNKNOWN, 2'd0, h.ptype, h.dest, hops_next, h.src, h.len);
    end
    fresh_words[fresh_words.size()-1].last = 1'b1;
    foreach (fresh_words[i]) route_words_due.push_back(fresh_words[i]);
  endfunction

  function automatic void check_field(string name, logic [7:0] e, logic [7:0] a);
    if (a !== e) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, e, a);
    end
  endfunction

  function automatic pkt_hdr_t hdr(logic [1:0] port, logic [7:0] t, logic [7:0] d,
                                   logic [7:0] hp, logic [7:0] s, logic [7:0] l,
                                   logic [7:0] o0, logic [7:0] o1, logic [7:0] o2,
                                   logic [7:0] o3);
    pkt_hdr_t h;
    h.port = port;
    h.ptype = t;
    h.dest = d;
    h.hops = hp;
    h.src = s;
    h.len = l;
    h.occ = {o3, o2, o1, o0};
    return h;
  endfunction

  function automatic void enqueue(pkt_hdr_t h);
    headers_pending.push_back(h);
    headers_issued++;
  endfunction

  // Most traffic uses the configured codes and a small pool of nodes so that
  // routes get learned and reused; the rest covers the full field ranges.
  function automatic pkt_hdr_t random_header();
    pkt_hdr_t h;
    int pick;
    h.port = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 99) < 80) begin
      case ($urandom_range(0, 3))
        0: h.ptype = std_code;
        1: h.ptype = ack_code;
        2: h.ptype = std_flood_code;
        default: h.ptype = ack_flood_code;
      endcase
    end else begin
      h.ptype = 8'($urandom);
    end
    pick = $urandom_range(0, 99);
    if (pick < 35) h.dest = my_addr_cfg;
    else if (pick < 80) h.dest = 8'(8'hA0 + $urandom_range(0, 7));
    else h.dest = 8'($urandom);
    if ($urandom_range(0, 99) < 75) h.src = 8'(8'hA0 + $urandom_range(0, 7));
    else h.src = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) h.hops = 8'($urandom_range(0, int'(max_hops_cfg)));
    else if (pick < 70) h.hops = 8'(int'(max_hops_cfg) + int'($urandom_range(0, 2)) - 1);
    else h.hops = 8'($urandom);
    h.len = 8'($urandom);
    for (int i = 0; i < 4; i++)
      h.occ[i] = ($urandom_range(0, 1) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    return h;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [7:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
  endtask

  task automatic apply_settings(logic [7:0] addr, logic [7:0] maxh, logic [7:0] cs,
                                logic [7:0] ca, logic [7:0] csf, logic [7:0] caf);
    write_reg(REG_MY_ADDRESS, addr);
    write_reg(REG_HOP_LIMIT, maxh);
    write_reg(REG_CODE_STANDARD, cs);
    write_reg(REG_CODE_ACK, ca);
    write_reg(REG_CODE_STANDARD_FLOOD, csf);
    write_reg(REG_CODE_ACK_FLOOD, caf);
    @(posedge clk);
    cfg_we <= 1'b0;
    my_addr_cfg = addr;
    max_hops_cfg = maxh;
    std_code = cs;
    ack_code = ca;
    std_flood_code = csf;
    ack_flood_code = caf;
  endtask

  task automatic drain();
    while (headers_accepted != headers_issued) @(posedge clk);
    while (route_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(int send_idle, int recv_stall);
    send_idle_pct = send_idle;
    recv_stall_pct = recv_stall;
    for (int i = 0; i < PHASE_HEADERS; i++) enqueue(random_header());
    drain();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_routing(hdr_live);
        headers_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (headers_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          hdr_live = headers_pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {6'b0, hdr_live.occ[3], hdr_live.occ[2], hdr_live.occ[1],
                      hdr_live.occ[0], hdr_live.len, hdr_live.src, hdr_live.hops,
                      hdr_live.dest, hdr_live.ptype, hdr_live.port};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen_word.action = action_t'(m_tuser);
        seen_word.port = m_tdata[1:0];
        seen_word.ptype = m_tdata[9:2];
        seen_word.dest = m_tdata[17:10];
        seen_word.hops = m_tdata[25:18];
        seen_word.src = m_tdata[33:26];
        seen_word.len = m_tdata[41:34];
        seen_word.last = m_tlast;
        if (route_words_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t ns: unexpected word, expected none, actual %p", $time,
                     seen_word);
        end else begin
          due_word = route_words_due.pop_front();
          check_field("action", 8'(due_word.action), 8'(m_tuser));
          check_field("out_port", 8'(due_word.port), 8'(seen_word.port));
          check_field("out_type", due_word.ptype, seen_word.ptype);
          check_field("out_dest", due_word.dest, seen_word.dest);
          check_field("out_hopcount", due_word.hops, seen_word.hops);
          check_field("out_src", due_word.src, seen_word.src);
          check_field("out_length", due_word.len, seen_word.len);
          check_field("last", 8'(due_word.last), 8'(seen_word.last));
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin
    foreach (hop_tbl[i]) hop_tbl[i] = 8'hFF;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Reset values of the registers: address 0, limit 254, codes 0 to 3.
    enqueue(hdr(2'd0, 8'd0, 8'd0, 8'd3, 8'd10, 8'd20, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd2, 8'd0, 8'd10, 8'd1, 8'd20, 8'd7, 8'd255, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd1, 8'd0, 8'd77, 8'd0, 8'd255, 8'd9, 8'd1, 8'd2, 8'd3, 8'd4));
    enqueue(hdr(2'd3, 8'd1, 8'd78, 8'd5, 8'd30, 8'd11, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd0, 8'd2, 8'd77, 8'd6, 8'd31, 8'd12, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd0, 8'd3, 8'd77, 8'd7, 8'd32, 8'd13, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd1, 8'd1, 8'd0, 8'd2, 8'd33, 8'd14, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd2, 8'd2, 8'd0, 8'd2, 8'd34, 8'd15, 8'd9, 8'd0, 8'd9, 8'd0));
    enqueue(hdr(2'd3, 8'd3, 8'd0, 8'd2, 8'd35, 8'd16, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd0, 8'd255, 8'd5, 8'd2, 8'd36, 8'd17, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd1, 8'd128, 8'd0, 8'd2, 8'd37, 8'd18, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd2, 8'd0, 8'd50, 8'd255, 8'd38, 8'd19, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd2, 8'd0, 8'd0, 8'd255, 8'd40, 8'd21, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd3, 8'd0, 8'd0, 8'd254, 8'd41, 8'd22, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd1, 8'd0, 8'd10, 8'd254, 8'd42, 8'd23, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd1, 8'd0, 8'd99, 8'd4, 8'd60, 8'd24, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd2, 8'd0, 8'd99, 8'd4, 8'd60, 8'd25, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd0, 8'd0, 8'd60, 8'd9, 8'd61, 8'd26, 8'd0, 8'd3, 8'd5, 8'd0));
    enqueue(hdr(2'd3, 8'd0, 8'd99, 8'd0, 8'd60, 8'd27, 8'd0, 8'd0, 8'd0, 8'd0));
    enqueue(hdr(2'd0, 8'd0, 8'd60, 8'd9, 8'd61, 8'd28, 8'd255, 8'd3, 8'd5, 8'd255));
    enqueue(hdr(2'd3, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                8'd255));
    enqueue(hdr(2'd3, 8'd255, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                8'd255));
    drain();

    apply_settings(8'h5A, 8'd254, 8'h10, 8'h11, 8'h12, 8'h13);
    run_phase(0, 0);
    apply_settings(8'hFF, 8'd0, 8'hFF, 8'h00, 8'h80, 8'h7F);
    run_phase(77, 0);
    // Overlapping codes exercise the type priority order.
    apply_settings(8'h00, 8'd16, 8'h44, 8'h45, 8'h45, 8'h44);
    run_phase(0, 77);
    apply_settings(8'h33, 8'd200, 8'h00, 8'h01, 8'h02, 8'h03);
    run_phase(31, 31);
    apply_settings(8'hA3, 8'd254, 8'h00, 8'h01, 8'h02, 8'h03);
    run_phase(0, 0);

    if (mismatches == 0 && route_words_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/htpr_pkg.sv
hw/rtl/htpr_regs.sv
hw/rtl/htpr_dp.sv
hw/rtl/htpr_ctrl.sv
hw/rtl/hop_table_packet_router.sv
bench/tb_top.sv
